FILE: src/tmd_pkg.sv
// ----------------------------------------------------------------------------
// tmd_pkg
// Shared constants, register indexes and the CORDIC arctangent table for the
// tilt, motion and tamper detector.
// ----------------------------------------------------------------------------
package tmd_pkg;

  localparam int DEF_SAMPLE_BITS     = 12;
  localparam int DEF_ANGLE_FRAC_BITS = 6;
  localparam int DEF_MAG_FRAC_BITS   = 4;

  localparam int ONE_G_COUNTS = 1024;
  localparam int CORDIC_STEPS = 18;
  localparam int DEG90_UNITS  = 5898240;
  localparam int ACC_BITS     = 25;
  localparam int ANGLE_BITS   = 14;

  localparam logic [1:0] REG_MOTION_DELTA = 2'd0;
  localparam logic [1:0] REG_MOTION_AXIS  = 2'd1;
  localparam logic [1:0] REG_TILT_DELTA   = 2'd2;
  localparam logic [1:0] REG_TILT_ANGLE   = 2'd3;

  localparam logic [15:0] RST_MOTION_DELTA = 16'd1638;
  localparam logic [12:0] RST_MOTION_AXIS  = 13'd512;
  localparam logic [13:0] RST_TILT_DELTA   = 14'd320;
  localparam logic [12:0] RST_TILT_ANGLE   = 13'd1920;

  localparam logic [1:0] MODE_UNLOCKED = 2'd0;
  localparam logic [1:0] MODE_LOCKED   = 2'd1;
  localparam logic [1:0] MODE_DRIVING  = 2'd2;

  function automatic logic [21:0] atan_unit(input logic [4:0] idx);
    logic [21:0] v;
    case (idx)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: src/tmd_if.sv
// ----------------------------------------------------------------------------
// tmd_if
// Valid/ready channels for sample items and result items.
// ----------------------------------------------------------------------------
interface tmd_in_if import tmd_pkg::*; #(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] accel_x;
  logic signed [SAMPLE_BITS-1:0] accel_y;
  logic signed [SAMPLE_BITS-1:0] accel_z;
  logic                          engine_on;
  logic                          ignition_on;
  logic                          vehicle_locked;

  modport source (output valid, accel_x, accel_y, accel_z, engine_on, ignition_on,
                  vehicle_locked, input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, engine_on, ignition_on,
                  vehicle_locked, output ready);
endinterface

interface tmd_out_if import tmd_pkg::*;;
  logic                         valid;
  logic                         ready;
  logic signed [ANGLE_BITS-1:0] pitch_angle;
  logic signed [ANGLE_BITS-1:0] roll_angle;
  logic                         motion_flag;
  logic                         tilt_flag;
  logic                         tamper_flag;
  logic                         alarm_request;
  logic [1:0]                   guard_mode;

  modport source (output valid, pitch_angle, roll_angle, motion_flag, tilt_flag,
                  tamper_flag, alarm_request, guard_mode, input ready);
  modport sink   (input valid, pitch_angle, roll_angle, motion_flag, tilt_flag,
                  tamper_flag, alarm_request, guard_mode, output ready);
endinterface

FILE: src/tmd_sqrt.sv
// ----------------------------------------------------------------------------
// tmd_sqrt
// Digit-serial square root, one result bit per cycle, rounded to nearest.
// ----------------------------------------------------------------------------
module tmd_sqrt import tmd_pkg::*; #(
  parameter int W = 26
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [W-1:0]   rad_i,
  output logic [W/2:0]   root_o,
  output logic           done_o
);
  localparam int N  = W / 2;
  localparam int CB = $clog2(N + 1);

  logic [W-1:0]   rad_q;
  logic [N:0]     rem_q;
  logic [N-1:0]   root_q;
  logic [CB-1:0]  cnt_q;
  logic           busy_q, done_q;
  logic [N+1:0]   rem_sh, trial, rem_sub;
  logic           ge;

  always_comb begin
    rem_sh  = {rem_q[N-1:0], rad_q[W-1:W-2]};
    trial   = {root_q, 2'b01};
    ge      = rem_sh >= trial;
    rem_sub = rem_sh - trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CB'(1);
      if (cnt_q == CB'(N - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[W-3:0], 2'b00};
      rem_q  <= ge ? rem_sub[N:0] : rem_sh[N:0];
      root_q <= {root_q[N-2:0], ge};
    end
  end

  assign root_o = {1'b0, root_q} + ((rem_q > {1'b0, root_q}) ? (N+1)'(1) : (N+1)'(0));
  assign done_o = done_q;

endmodule

FILE: src/tmd_cordic.sv
// ----------------------------------------------------------------------------
// tmd_cordic
// Vectoring CORDIC, one rotation per cycle, giving a rounded angle in degrees.
// ----------------------------------------------------------------------------
module tmd_cordic import tmd_pkg::*; #(
  parameter int OPP_BITS        = 12,
  parameter int ADJ_BITS        = 21,
  parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         opp_neg_i,
  input  logic [OPP_BITS-1:0]          opp_mag_i,
  input  logic [ADJ_BITS-1:0]          adj_i,
  output logic signed [ANGLE_BITS-1:0] angle_o,
  output logic                         done_o
);
  localparam int CW = ADJ_BITS + 3;
  localparam int SH = 16 - ANGLE_FRAC_BITS;

  logic signed [CW-1:0]       x_q, y_q, dx, dy;
  logic signed [ACC_BITS-1:0] acc_q, step_ang;
  logic [4:0]                 step_q;
  logic                       busy_q, done_q, zero_q, neg_q;
  logic [23:0]                acc_c, acc_r, ang_m;

  always_comb begin
    dx       = y_q[CW-1] ? -((-y_q) >>> step_q) : (y_q >>> step_q);
    dy       = x_q[CW-1] ? -((-x_q) >>> step_q) : (x_q >>> step_q);
    step_ang = signed'(ACC_BITS'(atan_unit(step_q)));
    if (acc_q[ACC_BITS-1]) begin
      acc_c = '0;
    end else if (acc_q[ACC_BITS-2:0] > 24'(DEG90_UNITS)) begin
      acc_c = 24'(DEG90_UNITS);
    end else begin
      acc_c = acc_q[ACC_BITS-2:0];
    end
    acc_r = acc_c + 24'(1 << (SH - 1));
    ang_m = acc_r >> SH;
    if (zero_q) begin
      angle_o = '0;
    end else if (neg_q) begin
      angle_o = (ang_m >= 24'd8192) ? 14'sh2000 : signed'(14'(~ang_m[13:0] + 14'd1));
    end else begin
      angle_o = (ang_m > 24'd8191) ? 14'sh1FFF : signed'(ang_m[13:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      step_q <= '0;
      if (opp_mag_i == '0 || adj_i == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        busy_q <= 1'b1;
        done_q <= 1'b0;
      end
    end else if (busy_q) begin
      step_q <= step_q + 5'd1;
      if (step_q == 5'(CORDIC_STEPS - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= CW'(adj_i);
      y_q    <= CW'({opp_mag_i, 8'd0});
      zero_q <= opp_mag_i == '0;
      neg_q  <= opp_neg_i;
      acc_q  <= (adj_i == '0) ? ACC_BITS'(DEG90_UNITS) : '0;
    end else if (busy_q) begin
      if (!y_q[CW-1]) begin
        x_q   <= x_q + dx;
        y_q   <= y_q - dy;
        acc_q <= acc_q + step_ang;
      end else begin
        x_q   <= x_q - dx;
        y_q   <= y_q + dy;
        acc_q <= acc_q - step_ang;
      end
    end
  end

  assign done_o = done_q;

endmodule

FILE: src/tilt_motion_tamper_detector_top.sv
// ----------------------------------------------------------------------------
// tilt_motion_tamper_detector_top
// An accepted item passes through the squares, the bit-serial square roots and
// the CORDIC loop before its result is loaded into the output register.
// Only one item is in flight: the next item can be taken at the earliest in
// the cycle after the result is loaded into the output register, and a
// stalled result holds the input off. Reset clears control, limits to their
// defaults and the previous magnitude, angles and tamper latch to zero.
// ----------------------------------------------------------------------------
module tilt_motion_tamper_detector_top import tmd_pkg::*; #(
  parameter int SAMPLE_BITS     = DEF_SAMPLE_BITS,
  parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS,
  parameter int MAG_FRAC_BITS   = DEF_MAG_FRAC_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  tmd_in_if.sink      in_if,
  tmd_out_if.source   out_if
);
  localparam int SB   = SAMPLE_BITS;
  localparam int SQW  = 2 * SB - 1;
  localparam int MAGW = 2 * SB + 2 + 2 * MAG_FRAC_BITS;
  localparam int ADJW = 2 * SB + 16;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQR  = 3'd1;
  localparam logic [2:0] ST_RTS  = 3'd2;
  localparam logic [2:0] ST_RTW  = 3'd3;
  localparam logic [2:0] ST_CRS  = 3'd4;
  localparam logic [2:0] ST_CRW  = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;

  logic [15:0] lim_md_q;
  logic [12:0] lim_ma_q;
  logic [13:0] lim_td_q;
  logic [12:0] lim_ta_q;

  logic [2:0]  state_q, state_d;
  logic [1:0]  cnt_q;
  logic signed [SB-1:0] ax_q, ay_q, az_q, sq_op;
  logic        eng_q, ign_q, lck_q;
  logic signed [2*SB-1:0] sq_prod;
  logic [SQW-1:0] xx_q, yy_q, zz_q;

  logic [15:0] last_mag_q;
  logic signed [ANGLE_BITS-1:0] last_pitch_q, last_roll_q;
  logic        tamper_q;

  logic [MAGW-1:0] mag_rad;
  logic [ADJW-1:0] pitch_rad, roll_rad;
  logic [MAGW/2:0] mag_root;
  logic [ADJW/2:0] pitch_adj, roll_adj;
  logic        mag_done, pitch_sq_done, roll_sq_done, pitch_done, roll_done;
  logic        root_start, cord_start;
  logic [SB-1:0] abs_x, abs_y;
  logic signed [ANGLE_BITS-1:0] pitch, roll;

  logic [15:0] mag, mag_diff;
  logic [31:0] z_dev, z_abs;
  logic signed [ANGLE_BITS:0] pd, rd;
  logic [ANGLE_BITS:0] pd_abs, rd_abs, p_abs, r_abs;
  logic        motion, tilt, alarm, tamper_d, load;
  logic [1:0]  mode;
  logic        wr_en;

  // Configuration port
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_md_q <= RST_MOTION_DELTA;
      lim_ma_q <= RST_MOTION_AXIS;
      lim_td_q <= RST_TILT_DELTA;
      lim_ta_q <= RST_TILT_ANGLE;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_MOTION_DELTA: lim_md_q <= pwdata[15:0];
        REG_MOTION_AXIS:  lim_ma_q <= pwdata[12:0];
        REG_TILT_DELTA:   lim_td_q <= pwdata[13:0];
        REG_TILT_ANGLE:   lim_ta_q <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_MOTION_DELTA: prdata = 32'(lim_md_q);
      REG_MOTION_AXIS:  prdata = 32'(lim_ma_q);
      REG_TILT_DELTA:   prdata = 32'(lim_td_q);
      REG_TILT_ANGLE:   prdata = 32'(lim_ta_q);
      default:          prdata = '0;
    endcase
  end

  // Sequencer
  assign in_if.ready = state_q == ST_IDLE;
  assign root_start  = state_q == ST_RTS;
  assign cord_start  = state_q == ST_CRS;
  assign load        = state_q == ST_FIN && (!out_if.valid || out_if.ready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_if.valid) state_d = ST_SQR;
      ST_SQR:  if (cnt_q == 2'd2) state_d = ST_RTS;
      ST_RTS:  state_d = ST_RTW;
      ST_RTW:  if (mag_done && pitch_sq_done && roll_sq_done) state_d = ST_CRS;
      ST_CRS:  state_d = ST_CRW;
      ST_CRW:  if (pitch_done && roll_done) state_d = ST_FIN;
      ST_FIN:  if (load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= (state_q == ST_SQR) ? cnt_q + 2'd1 : 2'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      ax_q  <= in_if.accel_x;
      ay_q  <= in_if.accel_y;
      az_q  <= in_if.accel_z;
      eng_q <= in_if.engine_on;
      ign_q <= in_if.ignition_on;
      lck_q <= in_if.vehicle_locked;
    end
  end

  // Squares, one axis a cycle through a shared multiplier
  always_comb begin
    case (cnt_q)
      2'd0:    sq_op = ax_q;
      2'd1:    sq_op = ay_q;
      default: sq_op = az_q;
    endcase
    sq_prod = sq_op * sq_op;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_SQR) begin
      case (cnt_q)
        2'd0:    xx_q <= sq_prod[SQW-1:0];
        2'd1:    yy_q <= sq_prod[SQW-1:0];
        default: zz_q <= sq_prod[SQW-1:0];
      endcase
    end
  end

  assign mag_rad   = (MAGW'(xx_q) + MAGW'(yy_q) + MAGW'(zz_q)) << (2 * MAG_FRAC_BITS);
  assign pitch_rad = (ADJW'(yy_q) + ADJW'(zz_q)) << 16;
  assign roll_rad  = (ADJW'(xx_q) + ADJW'(zz_q)) << 16;

  tmd_sqrt #(.W(MAGW)) u_mag_sqrt (
    .clk_i, .rst_ni, .start_i(root_start), .rad_i(mag_rad),
    .root_o(mag_root), .done_o(mag_done)
  );
  tmd_sqrt #(.W(ADJW)) u_pitch_sqrt (
    .clk_i, .rst_ni, .start_i(root_start), .rad_i(pitch_rad),
    .root_o(pitch_adj), .done_o(pitch_sq_done)
  );
  tmd_sqrt #(.W(ADJW)) u_roll_sqrt (
    .clk_i, .rst_ni, .start_i(root_start), .rad_i(roll_rad),
    .root_o(roll_adj), .done_o(roll_sq_done)
  );

  assign abs_x = ax_q[SB-1] ? SB'(-ax_q) : SB'(ax_q);
  assign abs_y = ay_q[SB-1] ? SB'(-ay_q) : SB'(ay_q);

  tmd_cordic #(.OPP_BITS(SB), .ADJ_BITS(ADJW/2 + 1), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS))
  u_pitch_cordic (
    .clk_i, .rst_ni, .start_i(cord_start), .opp_neg_i(ax_q[SB-1]), .opp_mag_i(abs_x),
    .adj_i(pitch_adj), .angle_o(pitch), .done_o(pitch_done)
  );
  tmd_cordic #(.OPP_BITS(SB), .ADJ_BITS(ADJW/2 + 1), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS))
  u_roll_cordic (
    .clk_i, .rst_ni, .start_i(cord_start), .opp_neg_i(ay_q[SB-1]), .opp_mag_i(abs_y),
    .adj_i(roll_adj), .angle_o(roll), .done_o(roll_done)
  );

  // Detection
  always_comb begin
    mag      = (32'(mag_root) > 32'd65535) ? 16'hFFFF : 16'(mag_root);
    mag_diff = (mag >= last_mag_q) ? mag - last_mag_q : last_mag_q - mag;
    z_dev    = 32'(signed'(az_q)) - 32'(ONE_G_COUNTS);
    z_abs    = z_dev[31] ? -z_dev : z_dev;
    pd       = (ANGLE_BITS+1)'(pitch) - (ANGLE_BITS+1)'(last_pitch_q);
    rd       = (ANGLE_BITS+1)'(roll) - (ANGLE_BITS+1)'(last_roll_q);
    pd_abs   = pd[ANGLE_BITS] ? -pd : pd;
    rd_abs   = rd[ANGLE_BITS] ? -rd : rd;
    p_abs    = pitch[ANGLE_BITS-1] ? -(ANGLE_BITS+1)'(pitch) : (ANGLE_BITS+1)'(pitch);
    r_abs    = roll[ANGLE_BITS-1] ? -(ANGLE_BITS+1)'(roll) : (ANGLE_BITS+1)'(roll);

    motion = mag_diff >= lim_md_q ||
             32'(abs_x) >= 32'(lim_ma_q) ||
             32'(abs_y) >= 32'(lim_ma_q) ||
             z_abs >= 32'(lim_ma_q);
    tilt   = pd_abs >= 15'(lim_td_q) || rd_abs >= 15'(lim_td_q) ||
             p_abs >= 15'(lim_ta_q) || r_abs >= 15'(lim_ta_q);

    if (eng_q || ign_q) begin
      mode = MODE_DRIVING;
    end else if (lck_q) begin
      mode = MODE_LOCKED;
    end else begin
      mode = MODE_UNLOCKED;
    end
    alarm    = (mode == MODE_LOCKED) && (motion || tilt);
    tamper_d = (mode == MODE_LOCKED) ? (tamper_q || alarm) : 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_mag_q   <= '0;
      last_pitch_q <= '0;
      last_roll_q  <= '0;
      tamper_q     <= 1'b0;
      out_if.valid <= 1'b0;
    end else if (load) begin
      last_mag_q   <= mag;
      last_pitch_q <= pitch;
      last_roll_q  <= roll;
      tamper_q     <= tamper_d;
      out_if.valid <= 1'b1;
    end else if (out_if.ready) begin
      out_if.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_if.pitch_angle   <= pitch;
      out_if.roll_angle    <= roll;
      out_if.motion_flag   <= motion;
      out_if.tilt_flag     <= tilt;
      out_if.tamper_flag   <= tamper_d;
      out_if.alarm_request <= alarm;
      out_if.guard_mode    <= mode;
    end
  end

endmodule

FILE: tb/tilt_motion_tamper_detector_top_test.sv
// ----------------------------------------------------------------------------
// tilt_motion_tamper_detector_top_test
// Drives accelerometer samples and vehicle flags into the detector and checks
// every result against a bit-exact predictor of the angles, motion, tilt,
// tamper and guard-mode logic, across several limit settings.
// ----------------------------------------------------------------------------
module tilt_motion_tamper_detector_top_test;
  import tmd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [11:0] x;
    logic signed [11:0] y;
    logic signed [11:0] z;
    logic               engine;
    logic               ign;
    logic               locked;
  } sample_t;

  typedef struct packed {
    logic signed [13:0] pitch;
    logic signed [13:0] roll;
    logic               motion;
    logic               tilt;
    logic               tamper;
    logic               alarm;
    logic [1:0]         mode;
  } verdict_t;

  typedef struct {
    sample_t  s;
    logic     known;
    verdict_t v;
  } row_t;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        psel = 0;
  logic        penable = 0;
  logic        pwrite = 0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  tmd_in_if  in_if ();
  tmd_out_if out_if ();

  tilt_motion_tamper_detector_top DUT (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_if (in_if.sink), .out_if (out_if.source)
  );

  always #5 clk_i = ~clk_i;

  longint unsigned lim_mag_delta, lim_axis, lim_tilt_delta, lim_tilt_angle;
  longint unsigned prev_mag;
  longint          prev_pitch, prev_roll;
  bit              tamper_held;

  verdict_t pending_q[$];
  int       errors = 0;
  int       mismatches = 0;
  bit       stim_done = 0;
  bit       hold_off = 0;

  function automatic longint unsigned isqrt_round(longint unsigned v);
    longint unsigned r = 0, rem = v, b = 64'd1 << 62;
    while (b > rem) b >>= 2;
    while (b != 0) begin
      if (rem >= r + b) begin
        rem -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    if (v - r * r > r) r++;
    return r;
  endfunction

  function automatic longint trunc_shift(longint v, int i);
    return (v >= 0) ? (v >>> i) : -((-v) >>> i);
  endfunction

  function automatic longint atan_step(int i);
    longint t[18] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                      29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29};
    return t[i];
  endfunction

  function automatic longint tilt_angle(longint opp, longint unsigned adj_sq);
    longint unsigned m;
    longint a, b, acc, da, db, res;
    m = (opp < 0) ? -opp : opp;
    b = m << 8;
    a = isqrt_round(adj_sq << 16);
    acc = 0;
    if (m == 0) return 0;
    if (a == 0) begin
      acc = DEG90_UNITS;
    end else begin
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        da = trunc_shift(b, i);
        db = trunc_shift(a, i);
        if (b >= 0) begin
          a += da; b -= db; acc += atan_step(i);
        end else begin
          a -= da; b += db; acc -= atan_step(i);
        end
      end
      if (acc < 0) acc = 0;
      if (acc > DEG90_UNITS) acc = DEG90_UNITS;
    end
    res = (acc + (64'sd1 << 9)) >>> 10;
    if (opp < 0) res = -res;
    if (res > 8191) res = 8191;
    if (res < -8192) res = -8192;
    return res;
  endfunction

  function automatic longint unsigned abs_gap(longint a, longint b);
    return (a >= b) ? a - b : b - a;
  endfunction

  function automatic verdict_t detect(sample_t s);
    verdict_t v;
    longint x, y, z, p, r;
    longint unsigned xx, yy, zz, mg;
    x = s.x; y = s.y; z = s.z;
    xx = x * x; yy = y * y; zz = z * z;
    mg = isqrt_round((xx + yy + zz) << 8);
    if (mg > 65535) mg = 65535;
    p = tilt_angle(x, yy + zz);
    r = tilt_angle(y, xx + zz);
    v.motion = abs_gap(mg, prev_mag) >= lim_mag_delta || abs_gap(x, 0) >= lim_axis ||
               abs_gap(y, 0) >= lim_axis || abs_gap(z, ONE_G_COUNTS) >= lim_axis;
    v.tilt = abs_gap(p, prev_pitch) >= lim_tilt_delta ||
             abs_gap(r, prev_roll) >= lim_tilt_delta ||
             abs_gap(p, 0) >= lim_tilt_angle || abs_gap(r, 0) >= lim_tilt_angle;
    v.mode = (s.engine || s.ign) ? MODE_DRIVING : (s.locked ? MODE_LOCKED : MODE_UNLOCKED);
    v.alarm = 0;
    if (v.mode == MODE_LOCKED) begin
      if (v.motion || v.tilt) begin
        tamper_held = 1;
        v.alarm = 1;
      end
    end else begin
      tamper_held = 0;
    end
    prev_mag = mg; prev_pitch = p; prev_roll = r;
    v.pitch = p[13:0];
    v.roll = r[13:0];
    v.tamper = tamper_held;
    return v;
  endfunction

  task automatic write_limit(logic [1:0] idx, logic [31:0] val);
    @(negedge clk_i);
    psel = 1; penable = 0; pwrite = 1; paddr = {idx, 2'b00}; pwdata = val;
    @(negedge clk_i);
    penable = 1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      REG_MOTION_DELTA: lim_mag_delta = val & 32'hFFFF;
      REG_MOTION_AXIS:  lim_axis = val & 32'h1FFF;
      REG_TILT_DELTA:   lim_tilt_delta = val & 32'h3FFF;
      default:          lim_tilt_angle = val & 32'h1FFF;
    endcase
    @(negedge clk_i);
    psel = 0; penable = 0; pwrite = 0;
  endtask

  task automatic drain();
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  task automatic send(sample_t s, logic known, verdict_t want);
    verdict_t v;
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 80) : $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_if.valid <= 0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid <= 1;
    {in_if.accel_x, in_if.accel_y, in_if.accel_z} <= {s.x, s.y, s.z};
    {in_if.engine_on, in_if.ignition_on, in_if.vehicle_locked} <= {s.engine, s.ign, s.locked};
    do @(posedge clk_i); while (!in_if.ready);
    v = detect(s);
    if (known && v !== want) begin
      errors++;
      $display("table row disagrees with predictor: %h vs %h", want, v);
    end
    pending_q.push_back(v);
    @(negedge clk_i);
  endtask

  function automatic sample_t rand_sample();
    sample_t s;
    int k;
    k = $urandom_range(0, 9);
    if (k < 6) begin
      s.x = 12'(int'($urandom_range(0, 800)) - 400);
      s.y = 12'(int'($urandom_range(0, 800)) - 400);
      s.z = 12'($urandom_range(600, 1400));
    end else begin
      s.x = 12'($urandom); s.y = 12'($urandom); s.z = 12'($urandom);
    end
    if (k == 9) begin
      s.x = ($urandom_range(0, 1)) ? 12'h800 : 12'h7FF;
      s.z = 0;
    end
    s.engine = ($urandom_range(0, 3) == 0);
    s.ign = ($urandom_range(0, 3) == 0);
    s.locked = 1'($urandom);
    return s;
  endfunction

  initial begin
    row_t rows[$];
    row_t rw;
    verdict_t z;
    z = '0;
    in_if.valid = 0;
    in_if.accel_x = 0; in_if.accel_y = 0; in_if.accel_z = 0;
    in_if.engine_on = 0; in_if.ignition_on = 0; in_if.vehicle_locked = 0;
    lim_mag_delta = RST_MOTION_DELTA; lim_axis = RST_MOTION_AXIS;
    lim_tilt_delta = RST_TILT_DELTA; lim_tilt_angle = RST_TILT_ANGLE;
    prev_mag = 0; prev_pitch = 0; prev_roll = 0; tamper_held = 0;

    // all-zero sample right after reset: no angle, z far from 1 g
    rw.s = '0; rw.known = 1;
    rw.v = '{pitch: 0, roll: 0, motion: 1, tilt: 0, tamper: 0, alarm: 0,
             mode: MODE_UNLOCKED};
    rows.push_back(rw);
    rw.known = 0;
    rw.s = '{x: 0, y: 0, z: 1024, engine: 0, ign: 0, locked: 1}; rows.push_back(rw);
    rw.s = '{x: 0, y: 0, z: 1024, engine: 0, ign: 0, locked: 1}; rows.push_back(rw);
    rw.s = '{x: 12'h7FF, y: 0, z: 0, engine: 0, ign: 0, locked: 1}; rows.push_back(rw);
    rw.s = '{x: 12'h800, y: 0, z: 0, engine: 0, ign: 0, locked: 1}; rows.push_back(rw);
    rw.s = '{x: 0, y: 12'h7FF, z: 0, engine: 0, ign: 0, locked: 1}; rows.push_back(rw);
    rw.s = '{x: 0, y: 12'h800, z: 0, engine: 0, ign: 0, locked: 0}; rows.push_back(rw);
    rw.s = '{x: 12'h800, y: 12'h800, z: 12'h800, engine: 1, ign: 0, locked: 1};
    rows.push_back(rw);
    rw.s = '{x: 12'h7FF, y: 12'h7FF, z: 12'h7FF, engine: 0, ign: 1, locked: 0};
    rows.push_back(rw);
    rw.s = '{x: 12'hFFF, y: 1, z: 12'h800, engine: 1, ign: 1, locked: 0}; rows.push_back(rw);
    rw.s = '{x: 100, y: 12'hF9C, z: 1000, engine: 0, ign: 0, locked: 1}; rows.push_back(rw);
    rw.s = '{x: 0, y: 0, z: 1024, engine: 0, ign: 0, locked: 1}; rows.push_back(rw);
    rw.s = '{x: 0, y: 0, z: 1024, engine: 0, ign: 0, locked: 0}; rows.push_back(rw);
    rw.s = '{x: 724, y: 0, z: 724, engine: 0, ign: 0, locked: 0}; rows.push_back(rw);

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    foreach (rows[i]) send(rows[i].s, rows[i].known, rows[i].known ? rows[i].v : z);
    in_if.valid <= 0;
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_limit(REG_MOTION_DELTA, 0); write_limit(REG_MOTION_AXIS, 0);
          write_limit(REG_TILT_DELTA, 0); write_limit(REG_TILT_ANGLE, 0);
        end
        1: begin
          write_limit(REG_MOTION_DELTA, 65535); write_limit(REG_MOTION_AXIS, 4096);
          write_limit(REG_TILT_DELTA, 11520); write_limit(REG_TILT_ANGLE, 5760);
        end
        2: begin
          write_limit(REG_MOTION_DELTA, 32'hFFFF_FFFF); write_limit(REG_MOTION_AXIS, 32'h1FFF);
          write_limit(REG_TILT_DELTA, 32'h3FFF); write_limit(REG_TILT_ANGLE, 32'h1FFF);
        end
        default: begin
          write_limit(REG_MOTION_DELTA, $urandom_range(0, 4000));
          write_limit(REG_MOTION_AXIS, $urandom_range(0, 700));
          write_limit(REG_TILT_DELTA, $urandom_range(0, 600));
          write_limit(REG_TILT_ANGLE, $urandom_range(0, 3000));
        end
      endcase
      for (int n = 0; n < 150; n++) begin
        if (ph == 3 && n == 20) hold_off = 1;
        if (ph == 4 && n == 40) begin
          in_if.valid <= 0;
          drain();
        end
        send(rand_sample(), 0, z);
      end
      in_if.valid <= 0;
      drain();
    end
    stim_done = 1;
  end

  initial begin
    int gap;
    out_if.ready = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        out_if.ready <= 0;
        repeat (400) @(negedge clk_i);
        hold_off = 0;
      end
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(0, 2);
      if ($urandom_range(0, 2) == 0) gap = 0;
      if (gap != 0) begin
        out_if.ready <= 0;
        repeat (gap) @(negedge clk_i);
      end
      out_if.ready <= 1;
    end
  end

  always @(posedge clk_i) begin
    verdict_t got, want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = '{out_if.pitch_angle, out_if.roll_angle, out_if.motion_flag, out_if.tilt_flag,
              out_if.tamper_flag, out_if.alarm_request, out_if.guard_mode};
      if (pending_q.size() == 0) begin
        errors++;
        $display("unexpected result item: %h", got);
      end else begin
        want = pending_q.pop_front();
        if (got !== want) begin
          errors++;
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: pitch %0d/%0d roll %0d/%0d mot %b/%b tilt %b/%b tmp %b/%b alm %b/%b mode %0d/%0d",
                     want.pitch, got.pitch, want.roll, got.roll, want.motion, got.motion,
                     want.tilt, got.tilt, want.tamper, got.tamper, want.alarm, got.alarm,
                     want.mode, got.mode);
        end
      end
    end
  end

  initial begin
    wait (stim_done);
    if (pending_q.size() != 0) errors++;
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
